// File: rtl/core/bsec_pkg.sv
// bsec_pkg: shared types, constants and arithmetic helpers of the split error counter
// used by every module in rtl/core; no dependencies of its own
package bsec_pkg;

  // row count limit and derived widths
  localparam int unsigned MAX_ROWS    = 65536;
  localparam int          CNT_W       = $clog2(MAX_ROWS + 1);
  localparam int          SUM_W       = CNT_W + 1;
  localparam int          FIELD_W     = 17;
  localparam int          CMP_W       = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;
  localparam int          WORD_W      = 64;
  localparam int          POP_W       = $clog2(WORD_W + 1);
  localparam int          QUEUE_DEPTH = 4;
  localparam int          QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [POP_W-1:0]   pop_t;
  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [WORD_W-1:0]  word_t;

  // input transaction
  typedef struct packed {
    word_t member_word;
    word_t feature_word;
    word_t positive_word;
    logic  last_word;
  } in_t;

  // result transaction
  typedef struct packed {
    logic   split_valid;
    logic   left_class;
    logic   right_class;
    field_t split_errors;
    logic   stop_label;
    field_t stop_errors;
    field_t node_rows;
    field_t left_rows;
  } out_t;

  // classified word, one queue entry
  typedef struct packed {
    pop_t member_cnt;
    pop_t pos_cnt;
    pop_t left_cnt;
    pop_t left_pos_cnt;
    logic last;
  } entry_t;

  // population count of one bitmap word
  function automatic pop_t popcount(input word_t w);
    pop_t n;
    n = '0;
    for (int i = 0; i < WORD_W; i++) begin
      n = n + pop_t'(w[i]);
    end
    return n;
  endfunction

  // add a word count to a running total, capped at the row limit
  function automatic cnt_t sat_add(input cnt_t acc, input pop_t inc);
    logic [SUM_W-1:0] s;
    s = SUM_W'(acc) + SUM_W'(inc);
    if (s > SUM_W'(MAX_ROWS)) begin
      return CNT_W'(MAX_ROWS);
    end
    return CNT_W'(s);
  endfunction

  // difference that never goes below zero
  function automatic cnt_t clamp_sub(input cnt_t a, input cnt_t b);
    return (a > b) ? (a - b) : '0;
  endfunction

  function automatic cnt_t min_cnt(input cnt_t a, input cnt_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

// File: rtl/core/bsec_front.sv
// bsec_front: classifies one input transaction into four word popcounts
// depends on bsec_pkg
module bsec_front (
  input  bsec_pkg::in_t    in_item,
  output bsec_pkg::entry_t entry
);
  import bsec_pkg::*;

  word_t left_bits;

  // rows with feature zero go left
  assign left_bits = in_item.member_word & ~in_item.feature_word;

  // per-word counts for the back end
  always_comb begin
    entry.member_cnt   = popcount(in_item.member_word);
    entry.pos_cnt      = popcount(in_item.member_word & in_item.positive_word);
    entry.left_cnt     = popcount(left_bits);
    entry.left_pos_cnt = popcount(left_bits & in_item.positive_word);
    entry.last         = in_item.last_word;
  end

endmodule

// File: rtl/core/bsec_queue.sv
// bsec_queue: short first-in first-out queue of classified words
// depends on bsec_pkg
module bsec_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bsec_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output bsec_pkg::entry_t head
);
  import bsec_pkg::*;

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// File: rtl/core/bsec_back.sv
// bsec_back: saturating totals per node and the three-stage result pipeline
// depends on bsec_pkg
module bsec_back (
  input  logic             clk,
  input  logic             rst,
  input  bsec_pkg::entry_t head,
  input  logic             empty,
  output logic             pop,
  input  bsec_pkg::field_t min_leaf_rows,
  output logic             out_valid,
  input  logic             out_stall,
  output bsec_pkg::out_t   out_item
);
  import bsec_pkg::*;

  // derived counts held between the two finishing stages
  typedef struct packed {
    cnt_t nl;
    cnt_t lp;
    cnt_t nr;
    cnt_t rp;
    cnt_t ln;
    logic split_valid;
    logic stop_label;
    cnt_t stop_errors;
    cnt_t total;
  } mid_t;

  logic advance;
  cnt_t member_total;
  cnt_t positive_total;
  cnt_t left_total;
  cnt_t left_positive_total;
  cnt_t member_next;
  cnt_t positive_next;
  cnt_t left_next;
  cnt_t left_positive_next;

  logic s1_valid;
  cnt_t s1_total;
  cnt_t s1_pos;
  cnt_t s1_left;
  cnt_t s1_left_pos;

  logic s2_valid;
  mid_t s2;
  mid_t s2_next;

  cnt_t             rn;
  cnt_t             left_err;
  cnt_t             right_err;
  logic [SUM_W-1:0] err_sum;
  cnt_t             err_sat;
  out_t             out_next;

  // whole pipeline moves unless a held result is stalled
  assign advance = !out_valid || !out_stall;
  assign pop     = advance && !empty;

  // running totals including the word at the head
  assign member_next        = sat_add(member_total, head.member_cnt);
  assign positive_next      = sat_add(positive_total, head.pos_cnt);
  assign left_next          = sat_add(left_total, head.left_cnt);
  assign left_positive_next = sat_add(left_positive_total, head.left_pos_cnt);

  // accumulate, clear after the last word of a node
  always_ff @(posedge clk) begin
    if (rst) begin
      member_total        <= '0;
      positive_total      <= '0;
      left_total          <= '0;
      left_positive_total <= '0;
    end else if (pop) begin
      if (head.last) begin
        member_total        <= '0;
        positive_total      <= '0;
        left_total          <= '0;
        left_positive_total <= '0;
      end else begin
        member_total        <= member_next;
        positive_total      <= positive_next;
        left_total          <= left_next;
        left_positive_total <= left_positive_next;
      end
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= pop && head.last;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  // first finishing stage: differences, leaf size check, stop leaf
  always_comb begin
    s2_next.nl          = s1_left;
    s2_next.lp          = s1_left_pos;
    s2_next.total       = s1_total;
    s2_next.nr          = clamp_sub(s1_total, s1_left);
    s2_next.rp          = clamp_sub(s1_pos, s1_left_pos);
    s2_next.ln          = clamp_sub(s1_left, s1_left_pos);
    s2_next.split_valid = (CMP_W'(s1_left) >= CMP_W'(min_leaf_rows)) &&
                          (CMP_W'(s2_next.nr) >= CMP_W'(min_leaf_rows));
    s2_next.stop_label  = s1_pos > clamp_sub(s1_total, s1_pos);
    s2_next.stop_errors = min_cnt(s1_pos, clamp_sub(s1_total, s1_pos));
  end

  // second finishing stage: child errors and labels
  always_comb begin
    rn        = clamp_sub(s2.nr, s2.rp);
    left_err  = min_cnt(s2.lp, s2.ln);
    right_err = min_cnt(s2.rp, rn);
    err_sum   = SUM_W'(left_err) + SUM_W'(right_err);
    err_sat   = (err_sum > SUM_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : CNT_W'(err_sum);
    out_next.split_valid  = s2.split_valid;
    out_next.left_class   = s2.lp > s2.ln;
    out_next.right_class  = s2.rp > rn;
    out_next.split_errors = FIELD_W'(err_sat);
    out_next.stop_label   = s2.stop_label;
    out_next.stop_errors  = FIELD_W'(s2.stop_errors);
    out_next.node_rows    = FIELD_W'(s2.total);
    out_next.left_rows    = FIELD_W'(s2.nl);
  end

  // stage payload registers
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_total    <= member_next;
      s1_pos      <= positive_next;
      s1_left     <= left_next;
      s1_left_pos <= left_positive_next;
      s2          <= s2_next;
      out_item    <= out_next;
    end
  end

endmodule

// File: rtl/core/binary_split_error_counter_core.sv
// binary_split_error_counter_core: top level of the split error counter
// depends on bsec_pkg, bsec_front, bsec_queue and bsec_back
//
// Usage: the input channel (in_valid, in_stall, in_item) carries one 64-row
// slice of the member, feature and positive bitmaps per transaction; the
// word flagged last_word closes a node. The output channel (out_valid,
// out_stall, out_item) carries one result per node: child labels, split
// errors, stop label and errors, node and left row counts, and split_valid.
// min_leaf_rows is written through cfg_wr_en / cfg_wr_data while idle.
// Throughput: one input word per cycle, sustained while out_stall is low.
// The front end takes a word whenever the four-entry queue has room; the
// back end retires one queue entry per cycle through its accumulator.
// Result path: after its last word is accepted, a result passes the queue,
// the accumulate register and two finishing stages before out_valid rises.
// Reset: all totals clear, the queue empties, no result is pending and
// min_leaf_rows returns to 1.
// Output stall: the result holds; the back end freezes, the queue fills and
// in_stall rises once four words wait.
module binary_split_error_counter_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  bsec_pkg::in_t    in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output bsec_pkg::out_t   out_item,
  input  logic             cfg_wr_en,
  input  bsec_pkg::field_t cfg_wr_data
);
  import bsec_pkg::*;

  entry_t front_entry;
  entry_t head;
  logic   queue_full;
  logic   queue_empty;
  logic   pop;
  logic   push;
  field_t min_leaf_rows;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_leaf_rows <= FIELD_W'(1);
    end else if (cfg_wr_en) begin
      min_leaf_rows <= cfg_wr_data;
    end
  end

  // input transaction handshake
  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  bsec_front u_front (
    .in_item (in_item),
    .entry   (front_entry)
  );

  bsec_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (front_entry),
    .full       (queue_full),
    .pop        (pop),
    .empty      (queue_empty),
    .head       (head)
  );

  bsec_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (queue_empty),
    .pop           (pop),
    .min_leaf_rows (min_leaf_rows),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_item      (out_item)
  );

endmodule

// File: rtl/core/bsec_checker.sv
// bsec_checker: port-level checks of the split error counter, bound to the top level
// depends on bsec_pkg and binary_split_error_counter_core
module bsec_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input bsec_pkg::out_t   out_item
);
  import bsec_pkg::*;

  // a stalled result stays offered
  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction dropped while stalled");

  // a stalled result keeps its payload
  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_item))
    else $error("result payload changed while stalled");

  // nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

  // input side is ready right after reset
  a_reset_ready: assert property (@(posedge clk)
    rst |=> !in_stall)
    else $error("input stalled after reset");

  // left child and stop errors never exceed what the node holds
  a_counts_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.left_rows <= out_item.node_rows) &&
                  (({1'b0, out_item.stop_errors} << 1) <= {1'b0, out_item.node_rows}))
    else $error("result counts inconsistent");

endmodule

bind binary_split_error_counter_core bsec_checker u_bsec_checker (.*);

// File: dv/tb_binary_split_error_counter_core.sv
// tb_binary_split_error_counter_core: self-checking bench for the split error counter core
// drives bitmap words with random idle and stall, predicts each node result and checks it
// depends on bsec_pkg and binary_split_error_counter_core
`timescale 1ns / 100ps

module tb_binary_split_error_counter_core;
  import bsec_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 8;
  localparam word_t ONES        = '1;

  logic   clk;
  logic   rst;
  logic   in_valid;
  logic   in_stall;
  in_t    in_item;
  logic   out_valid;
  logic   out_stall;
  out_t   out_item;
  logic   cfg_wr_en;
  field_t cfg_wr_data;

  // predictor state and configuration copy
  cnt_t   member_total;
  cnt_t   positive_total;
  cnt_t   left_total;
  cnt_t   left_positive_total;
  field_t leaf_floor;
  out_t   expected_scores[$];

  int mismatches;
  int stall_free_cycles;
  int send_idle_pct;
  int recv_stall_pct;

  binary_split_error_counter_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // running total capped at the row limit
  function automatic cnt_t capped_sum(input cnt_t acc, input int unsigned inc);
    int unsigned s;
    s = acc + inc;
    return (s > MAX_ROWS) ? cnt_t'(MAX_ROWS) : cnt_t'(s);
  endfunction

  function automatic int unsigned floor_sub(input int unsigned a, input int unsigned b);
    return (a > b) ? a - b : 0;
  endfunction

  function automatic in_t make_slice(input word_t m, input word_t f, input word_t p,
                                     input logic l);
    in_t w;
    w.member_word   = m;
    w.feature_word  = f;
    w.positive_word = p;
    w.last_word     = l;
    return w;
  endfunction

  // random bitmap with a chosen density
  function automatic word_t bitmap_word();
    word_t a;
    word_t b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(7))
      0:       return '0;
      1:       return ONES;
      2:       return a & b & {$urandom, $urandom};
      3:       return a | b;
      default: return a;
    endcase
  endfunction

  // accumulate one word and score the node on its last word
  task automatic tally_word(input in_t w);
    word_t left_bits;
    int unsigned tot, pos, nl, lp, neg, nr, rp, ln, rn, err;
    out_t s;
    left_bits = w.member_word & ~w.feature_word;
    member_total        = capped_sum(member_total, $countones(w.member_word));
    positive_total      = capped_sum(positive_total,
                                     $countones(w.member_word & w.positive_word));
    left_total          = capped_sum(left_total, $countones(left_bits));
    left_positive_total = capped_sum(left_positive_total,
                                     $countones(left_bits & w.positive_word));
    if (w.last_word) begin
      tot = member_total;
      pos = positive_total;
      nl  = left_total;
      lp  = left_positive_total;
      neg = floor_sub(tot, pos);
      nr  = floor_sub(tot, nl);
      rp  = floor_sub(pos, lp);
      ln  = floor_sub(nl, lp);
      rn  = floor_sub(nr, rp);
      err = ((lp < ln) ? lp : ln) + ((rp < rn) ? rp : rn);
      if (err > MAX_ROWS) begin
        err = MAX_ROWS;
      end
      s.split_valid  = (nl >= leaf_floor) && (nr >= leaf_floor);
      s.left_class   = lp > ln;
      s.right_class  = rp > rn;
      s.split_errors = field_t'(err);
      s.stop_label   = pos > neg;
      s.stop_errors  = field_t'((pos < neg) ? pos : neg);
      s.node_rows    = field_t'(tot);
      s.left_rows    = field_t'(nl);
      expected_scores.insert(expected_scores.size(), s);
      member_total        = '0;
      positive_total      = '0;
      left_total          = '0;
      left_positive_total = '0;
    end
  endtask

  // offer one word, hold it until taken, then predict
  task automatic send_word(input in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= w;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    tally_word(w);
  endtask

  // let every pending result out, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_scores.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only called while idle
  task automatic set_leaf_floor(input field_t v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    leaf_floor = v;
    @(posedge clk);
  endtask

  // field extremes, empty nodes, ties and a multi-word node
  task automatic test_directed_cases();
    send_word(make_slice('0, '0, '0, 1'b1));
    send_word(make_slice(ONES, '0, ONES, 1'b1));
    send_word(make_slice(ONES, ONES, '0, 1'b1));
    send_word(make_slice(ONES, 64'hFFFFFFFF_00000000, 64'hFFFF0000_FFFF0000, 1'b1));
    send_word(make_slice('0, ONES, ONES, 1'b1));
    send_word(make_slice(64'hAAAAAAAA_AAAAAAAA, 64'h0F0F0F0F_0F0F0F0F,
                         64'h33333333_33333333, 1'b0));
    send_word(make_slice(64'h55555555_55555555, 64'hF0F0F0F0_F0F0F0F0,
                         64'hCCCCCCCC_CCCCCCCC, 1'b0));
    send_word(make_slice(ONES, '0, 64'h80000000_00000001, 1'b0));
    send_word(make_slice(64'h1, '0, 64'h1, 1'b1));
    send_word(make_slice(64'h80000000_00000000, 64'h80000000_00000000,
                         64'h80000000_00000000, 1'b1));
    send_word(make_slice(ONES, 64'hFFFFFFFF_FFFF0000, 64'hFFFFFFFF_FFFF0001, 1'b1));
    send_word(make_slice(ONES, 64'h0000FFFF_FFFFFFFF, 64'h00000000_0000FFFF, 1'b1));
    drain();
  endtask

  // split_valid around the leaf size limit
  task automatic test_leaf_floor();
    set_leaf_floor('0);
    send_word(make_slice('0, '0, '0, 1'b1));
    send_word(make_slice(ONES, '0, ONES, 1'b1));
    drain();
    set_leaf_floor(field_t'(32));
    send_word(make_slice(ONES, 64'hFFFFFFFF_00000000, 64'h0F0F0F0F_0F0F0F0F, 1'b1));
    send_word(make_slice(ONES, 64'hFFFFFFFE_00000000, ONES, 1'b1));
    drain();
    set_leaf_floor(field_t'(33));
    send_word(make_slice(ONES, 64'hFFFFFFFF_00000000, 64'h0F0F0F0F_0F0F0F0F, 1'b1));
    drain();
    set_leaf_floor(field_t'(MAX_ROWS - 1));
    send_word(make_slice(ONES, 64'hFFFFFFFF_00000000, ONES, 1'b1));
    drain();
    set_leaf_floor(field_t'(1));
  endtask

  // random nodes under one idle and stall setting
  task automatic test_random_nodes(input int idle_pct, input int stall_pct,
                                   input int word_budget);
    int sent;
    int node_len;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    set_leaf_floor(($urandom_range(3) == 0) ? '0 : field_t'($urandom_range(400)));
    sent = 0;
    while (sent < word_budget) begin
      node_len = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      for (int i = 0; i < node_len; i++) begin
        send_word(make_slice(bitmap_word(), bitmap_word(), bitmap_word(),
                             i == node_len - 1));
      end
      sent += node_len;
    end
    drain();
  endtask

  // result checker
  task automatic check_field(input string name, input logic [16:0] want,
                             input logic [16:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_result
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_scores.size() == 0) begin
        $error("result transaction with none expected: %p", out_item);
        mismatches++;
      end else begin
        want = expected_scores.pop_front();
        check_field("split_valid", want.split_valid, out_item.split_valid);
        check_field("left_class", want.left_class, out_item.left_class);
        check_field("right_class", want.right_class, out_item.right_class);
        check_field("split_errors", want.split_errors, out_item.split_errors);
        check_field("stop_label", want.stop_label, out_item.stop_label);
        check_field("stop_errors", want.stop_errors, out_item.stop_errors);
        check_field("node_rows", want.node_rows, out_item.node_rows);
        check_field("left_rows", want.left_rows, out_item.left_rows);
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stall_free_cycles <= 0;
    end else if (stall_free_cycles >= WATCHDOG_LIMIT) begin
      $display("binary_split_error_counter_core regression: fail");
      $finish;
    end else begin
      stall_free_cycles <= stall_free_cycles + 1;
    end
  end

  // test sequence
  initial begin
    rst                 <= 1'b1;
    in_valid            <= 1'b0;
    in_item             <= '0;
    cfg_wr_en           <= 1'b0;
    cfg_wr_data         <= '0;
    mismatches          = 0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    leaf_floor          = field_t'(1);
    member_total        = '0;
    positive_total      = '0;
    left_total          = '0;
    left_positive_total = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    test_directed_cases();
    test_leaf_floor();
    test_random_nodes(0, 0, 215);
    test_random_nodes(80, 0, 210);
    test_random_nodes(0, 80, 210);
    test_random_nodes(13, 13, 215);

    if (mismatches == 0) begin
      $display("binary_split_error_counter_core regression: pass");
    end else begin
      $display("binary_split_error_counter_core regression: fail");
    end
    $finish;
  end

endmodule
